[design/cps_pkg.sv]
// Shared types for the closest-point-on-segment block.
package cps_pkg;
   // Pipeline control that travels alongside the data.
   typedef struct packed {
      logic valid;
      logic degen;
   } ctl_type;
endpackage

[design/cps_div_cell.sv]
// One restoring-division cell: yields one quotient bit per stage.
module cps_div_cell #(
   parameter int DEN_BITS = 34,
   parameter int Q_BITS   = 17,
   parameter int C_BITS   = 17
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  cps_pkg::ctl_type     ctl_in,
   input  logic [DEN_BITS-1:0]  rem_in,
   input  logic [DEN_BITS-1:0]  den_in,
   input  logic [Q_BITS-1:0]    quo_in,
   input  logic [3*C_BITS-1:0]  side_in,
   output cps_pkg::ctl_type     ctl_out,
   output logic [DEN_BITS-1:0]  rem_out,
   output logic [DEN_BITS-1:0]  den_out,
   output logic [Q_BITS-1:0]    quo_out,
   output logic [3*C_BITS-1:0]  side_out
);
   cps_pkg::ctl_type        ctl_ff;
   logic [DEN_BITS-1:0]     rem_ff, rem_in_w, den_ff;
   logic [Q_BITS-1:0]       quo_ff, quo_in_w;
   logic [3*C_BITS-1:0]     side_ff;
   logic [DEN_BITS:0]       shifted;

   always_comb begin
      shifted = {rem_in, 1'b0};
      if (shifted >= {1'b0, den_in}) begin
         rem_in_w = DEN_BITS'(shifted - {1'b0, den_in});
         quo_in_w = {quo_in[Q_BITS-2:0], 1'b1};
      end else begin
         rem_in_w = shifted[DEN_BITS-1:0];
         quo_in_w = {quo_in[Q_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
      if (advance) begin
         rem_ff  <= rem_in_w;
         den_ff  <= den_in;
         quo_ff  <= quo_in_w;
         side_ff <= side_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign rem_out  = rem_ff;
   assign den_out  = den_ff;
   assign quo_out  = quo_ff;
   assign side_out = side_ff;
endmodule

[design/closest_point_on_segment_unit.sv]
// Top level: closest point on a 3D segment, fully pipelined.
//
// Input channel req_*: segment start, end and query point, signed fixed point.
// Result channel rsp_*: nearest point on the segment, clamped t and a
// degenerate flag for a zero-length segment (t = 0, point = start).
// Both channels: an item moves when valid is high and stall is low.
//
// Throughput: one item per cycle unless the output is stalled. Results reach
// rsp_valid through the difference, product and dot-sum stages, the chain of
// division cells (one quotient bit per cell), then scale and output stages;
// the clamp is combinational. The whole pipeline advances as one; when
// rsp_stall is high and the output holds an item, every stage holds and
// req_stall is raised. Bubbles are not squeezed out: while the output is
// empty, every stage advances even with rsp_stall high.
// Reset clears all valid bits; payload registers are not reset.
module closest_point_on_segment_unit #(
   parameter int COORD_BITS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_start_z,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] req_end_z,
   input  logic signed [COORD_BITS-1:0] req_query_x,
   input  logic signed [COORD_BITS-1:0] req_query_y,
   input  logic signed [COORD_BITS-1:0] req_query_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_near_x,
   output logic signed [COORD_BITS-1:0] rsp_near_y,
   output logic signed [COORD_BITS-1:0] rsp_near_z,
   output logic [T_FRAC_BITS:0]        rsp_param_t,
   output logic                        rsp_degenerate
);
   localparam int DB = COORD_BITS + 1;       // difference width
   localparam int PB = 2 * DB;               // product width
   localparam int SB = PB + 2;               // dot-sum width
   localparam int TB = T_FRAC_BITS + 1;      // t width
   localparam int MB = DB + TB + 1;          // scale product width

   logic advance;
   // Whole pipeline moves unless the output holds an item that is stalled.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Stage 1: differences.
   logic                 v1_ff;
   logic signed [DB-1:0] l_ff [3];
   logic signed [DB-1:0] a_ff [3];
   logic signed [COORD_BITS-1:0] s1_ff [3];
   logic signed [COORD_BITS-1:0] st [3], en [3], qu [3];
   assign st = '{req_start_x, req_start_y, req_start_z};
   assign en = '{req_end_x, req_end_y, req_end_z};
   assign qu = '{req_query_x, req_query_y, req_query_z};

   // Stage 2: products.
   logic                 v2_ff;
   logic signed [PB-1:0] la_ff [3], ll_ff [3];
   logic signed [DB-1:0] l2_ff [3];
   logic signed [COORD_BITS-1:0] s2_ff [3];

   // Stage 3: dot sums, classification.
   logic                 v3_ff, dg3_ff, one3_ff, zero3_ff;
   logic [SB-1:0]        num3_ff, den3_ff;
   logic signed [DB-1:0] l3_ff [3];
   logic signed [COORD_BITS-1:0] s3_ff [3];
   logic signed [SB-1:0] num_w, den_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            l_ff[i]  <= DB'(en[i]) - DB'(st[i]);
            a_ff[i]  <= DB'(qu[i]) - DB'(st[i]);
            s1_ff[i] <= st[i];
            la_ff[i] <= PB'(l_ff[i]) * PB'(a_ff[i]);
            ll_ff[i] <= PB'(l_ff[i]) * PB'(l_ff[i]);
            l2_ff[i] <= l_ff[i];
            s2_ff[i] <= s1_ff[i];
            l3_ff[i] <= l2_ff[i];
            s3_ff[i] <= s2_ff[i];
         end
         dg3_ff   <= (den_w == '0);
         zero3_ff <= (den_w == '0) || (num_w <= 0);
         one3_ff  <= (num_w >= den_w);
         num3_ff  <= num_w;
         den3_ff  <= den_w;
      end
   end

   assign num_w = SB'(la_ff[0]) + SB'(la_ff[1]) + SB'(la_ff[2]);
   assign den_w = SB'(ll_ff[0]) + SB'(ll_ff[1]) + SB'(ll_ff[2]);

   // Division chain. Side bus carries the segment vector; start points
   // ride a parallel bus through the same cells.
   localparam int CB = DB;
   localparam int NC = T_FRAC_BITS;
   cps_pkg::ctl_type     c_ctl [NC+1];
   logic [SB-1:0]        c_rem [NC+1];
   logic [SB-1:0]        c_den [NC+1];
   logic [TB-1:0]        c_quo [NC+1];
   logic [3*CB-1:0]      c_side [NC+1];
   cps_pkg::ctl_type     k_ctl [NC];
   logic [SB-1:0]        k_rem [NC], k_den [NC];
   logic [TB-1:0]        k_quo [NC];
   logic [3*CB-1:0]      k_side [NC];
   logic                 flag_one [NC+1], flag_zero [NC+1];
   logic [3*COORD_BITS-1:0] start_bus [NC+1];

   assign c_ctl[0]  = '{valid: v3_ff, degen: dg3_ff};
   assign c_rem[0]  = num3_ff;
   assign c_den[0]  = den3_ff;
   assign c_quo[0]  = '0;
   assign c_side[0] = {l3_ff[2], l3_ff[1], l3_ff[0]};
   assign flag_one[0]  = one3_ff;
   assign flag_zero[0] = zero3_ff;
   assign start_bus[0] = {s3_ff[2], s3_ff[1], s3_ff[0]};

   for (genvar g = 0; g < NC; g++) begin : g_cell
      logic f1_ff, f0_ff;
      logic [3*COORD_BITS-1:0] sb_ff;
      cps_div_cell #(.DEN_BITS(SB), .Q_BITS(TB), .C_BITS(CB)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .ctl_in(c_ctl[g]), .rem_in(c_rem[g]), .den_in(c_den[g]),
         .quo_in(c_quo[g]), .side_in(c_side[g]),
         .ctl_out(k_ctl[g]), .rem_out(k_rem[g]), .den_out(k_den[g]),
         .quo_out(k_quo[g]), .side_out(k_side[g])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            f1_ff <= flag_one[g];
            f0_ff <= flag_zero[g];
            sb_ff <= start_bus[g];
         end
      end
      assign c_ctl[g+1]  = k_ctl[g];
      assign c_rem[g+1]  = k_rem[g];
      assign c_den[g+1]  = k_den[g];
      assign c_quo[g+1]  = k_quo[g];
      assign c_side[g+1] = k_side[g];
      assign flag_one[g+1]  = f1_ff;
      assign flag_zero[g+1] = f0_ff;
      assign start_bus[g+1] = sb_ff;
   end

   // Clamp to [0, one].
   logic [TB-1:0] t_w;
   always_comb begin
      priority if (flag_zero[NC]) begin
         t_w = '0;
      end else if (flag_one[NC]) begin
         t_w = TB'(1) << T_FRAC_BITS;
      end else begin
         t_w = c_quo[NC];
      end
   end

   // Stage: scale products L * t.
   logic                 vm_ff, dgm_ff;
   logic [TB-1:0]        tm_ff;
   logic signed [MB-1:0] m_ff [3];
   logic signed [COORD_BITS-1:0] sm_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (advance) begin
         vm_ff <= c_ctl[NC].valid;
      end
      if (advance) begin
         dgm_ff <= c_ctl[NC].degen;
         tm_ff  <= t_w;
         for (int i = 0; i < 3; i++) begin
            m_ff[i]  <= MB'($signed(c_side[NC][i*CB +: CB])) *
                        MB'($signed({1'b0, t_w}));
            sm_ff[i] <= $signed(start_bus[NC][i*COORD_BITS +: COORD_BITS]);
         end
      end
   end

   // Output register: floor shift and add start.
   logic                 vo_ff, dgo_ff;
   logic [TB-1:0]        to_ff;
   logic signed [COORD_BITS-1:0] no_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (advance) begin
         vo_ff <= vm_ff;
      end
      if (advance) begin
         dgo_ff <= dgm_ff;
         to_ff  <= tm_ff;
         for (int i = 0; i < 3; i++) begin
            no_ff[i] <= COORD_BITS'(sm_ff[i] + COORD_BITS'(m_ff[i] >>> T_FRAC_BITS));
         end
      end
   end

   assign rsp_valid      = vo_ff;
   assign rsp_near_x     = no_ff[0];
   assign rsp_near_y     = no_ff[1];
   assign rsp_near_z     = no_ff[2];
   assign rsp_param_t    = to_ff;
   assign rsp_degenerate = dgo_ff;
endmodule

[design/cps_checker.sv]
// Port-level checks for the closest-point-on-segment block.
module cps_checker #(
   parameter int T_FRAC_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [T_FRAC_BITS:0]   rsp_param_t,
   input logic                   rsp_degenerate
);
   localparam logic [T_FRAC_BITS:0] TOne = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_param_t <= TOne) else $error("t above one");
   a_degen_t: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_param_t == '0) else $error("degenerate t");
   a_back: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("needless stall");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_param_t))
      else $error("stalled item changed");
endmodule

bind closest_point_on_segment_unit cps_checker #(
   .T_FRAC_BITS(T_FRAC_BITS)
) u_cps_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_param_t(rsp_param_t), .rsp_degenerate(rsp_degenerate)
);

[tb/tb_closest_point_on_segment_unit.sv]
// Testbench for the closest-point-on-segment unit: predicted results, random stalls.
module tb_closest_point_on_segment_unit;
   localparam int CB = 16;
   localparam int TF = 16;
   localparam int LATENCY = TF + 5;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 450;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct {
      coord_type s[3];
      coord_type e[3];
      coord_type q[3];
   } segment_query_type;

   typedef struct {
      coord_type n[3];
      logic [TF:0] t;
      logic degen;
   } nearest_point_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   coord_type req_start_x = '0, req_start_y = '0, req_start_z = '0;
   coord_type req_end_x = '0, req_end_y = '0, req_end_z = '0;
   coord_type req_query_x = '0, req_query_y = '0, req_query_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   coord_type rsp_near_x, rsp_near_y, rsp_near_z;
   logic [TF:0] rsp_param_t;
   logic rsp_degenerate;

   closest_point_on_segment_unit #(.COORD_BITS(CB), .T_FRAC_BITS(TF)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_start_z(req_start_z),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_end_z(req_end_z),
      .req_query_x(req_query_x), .req_query_y(req_query_y), .req_query_z(req_query_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_near_x(rsp_near_x), .rsp_near_y(rsp_near_y), .rsp_near_z(rsp_near_z),
      .rsp_param_t(rsp_param_t), .rsp_degenerate(rsp_degenerate)
   );

   always #5 clock = ~clock;

   segment_query_type pending_queries[$];
   nearest_point_type expected_points[$];
   int error_count = 0;
   bit stimulus_done = 0;
   bit calm_phase = 0;      // no idling near the end
   bit hold_output = 0;     // long receiver hold-off
   int idle_count = 0;

   // Closest point: t = clamp(L.A / L.L), truncated division, then floor scale.
   function automatic nearest_point_type closest_point(segment_query_type sq);
      nearest_point_type r;
      longint l[3], a[3], num, den, rem, p;
      logic [TF:0] t;
      num = 0;
      den = 0;
      for (int i = 0; i < 3; i++) begin
         l[i] = longint'(sq.e[i]) - longint'(sq.s[i]);
         a[i] = longint'(sq.q[i]) - longint'(sq.s[i]);
         num += l[i] * a[i];
         den += l[i] * l[i];
      end
      r.degen = (den == 0);
      if (r.degen || num <= 0) begin
         t = '0;
      end else if (num >= den) begin
         t = (TF+1)'(1) << TF;
      end else begin
         rem = num;
         t = '0;
         for (int b = 0; b < TF; b++) begin
            rem = rem << 1;
            t = t << 1;
            if (rem >= den) begin
               rem -= den;
               t[0] = 1'b1;
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         p = l[i] * longint'({1'b0, t});
         r.n[i] = coord_type'(longint'(sq.s[i]) + (p >>> TF));
      end
      r.t = t;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'(16'sh7fff);
         1: return coord_type'(16'sh8000);
         2: return coord_type'($urandom_range(0, 64) - 32);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic add_query(coord_type s[3], coord_type e[3], coord_type q[3]);
      segment_query_type sq;
      sq.s = s;
      sq.e = e;
      sq.q = q;
      pending_queries.push_back(sq);
   endtask

   // Driver: holds payload while stalled, idles in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            void'(pending_queries.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (idle_count > 0) begin
               idle_count <= idle_count - 1;
               req_valid <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
               idle_count <= $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else if (pending_queries.size() > 0) begin
               segment_query_type sq;
               sq = pending_queries[0];
               req_valid <= 1'b1;
               {req_start_x, req_start_y, req_start_z} <= {sq.s[0], sq.s[1], sq.s[2]};
               {req_end_x, req_end_y, req_end_z} <= {sq.e[0], sq.e[1], sq.e[2]};
               {req_query_x, req_query_y, req_query_z} <= {sq.q[0], sq.q[1], sq.q[2]};
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Predict on acceptance.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         segment_query_type sq;
         sq.s = '{req_start_x, req_start_y, req_start_z};
         sq.e = '{req_end_x, req_end_y, req_end_z};
         sq.q = '{req_query_x, req_query_y, req_query_z};
         expected_points.push_back(closest_point(sq));
      end
   end

   // Receiver stall: random bursts, or forced hold-off.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (hold_output) begin
         rsp_stall <= 1'b1;
      end else if (calm_phase) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare each result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $display("unexpected result item");
            error_count++;
         end else begin
            nearest_point_type w;
            w = expected_points.pop_front();
            if (rsp_near_x !== w.n[0]) report_mismatch("near_x", rsp_near_x, w.n[0]);
            if (rsp_near_y !== w.n[1]) report_mismatch("near_y", rsp_near_y, w.n[1]);
            if (rsp_near_z !== w.n[2]) report_mismatch("near_z", rsp_near_z, w.n[2]);
            if (rsp_param_t !== w.t) report_mismatch("param_t", rsp_param_t, w.t);
            if (rsp_degenerate !== w.degen)
               report_mismatch("degenerate", rsp_degenerate, w.degen);
         end
      end
   end

   // Watchdog: cycles with no acceptance on either side.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_output) begin
         quiet_cycles <= 0;
      end else if (!stimulus_done || expected_points.size() != 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[closest_point_on_segment_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      coord_type s[3], e[3], q[3];
      coord_type mx, mn;
      mx = 16'sh7fff;
      mn = 16'sh8000;
      // Directed: zero length, behind start, beyond end, extremes, interior.
      add_query('{0, 0, 0}, '{0, 0, 0}, '{5, 5, 5});
      add_query('{mx, mn, 7}, '{mx, mn, 7}, '{mn, mx, 0});
      add_query('{0, 0, 0}, '{256, 0, 0}, '{-100, 3, 3});
      add_query('{0, 0, 0}, '{256, 0, 0}, '{1000, 0, 0});
      add_query('{0, 0, 0}, '{256, 0, 0}, '{256, 9, 0});
      add_query('{0, 0, 0}, '{256, 256, 0}, '{100, 30, 0});
      add_query('{mn, mn, mn}, '{mx, mx, mx}, '{0, 0, 0});
      add_query('{mx, mx, mx}, '{mn, mn, mn}, '{1, -1, 3});
      add_query('{mn, mx, mn}, '{mx, mn, mx}, '{mx, mx, mx});
      add_query('{mx, mn, mx}, '{mn, mx, mn}, '{mn, mn, 0});
      add_query('{10, -20, 30}, '{-300, 400, -500}, '{-7, 100, -80});
      add_query('{0, 0, 0}, '{1, 0, 0}, '{0, 0, 0});
      add_query('{0, 0, 0}, '{3, 0, 0}, '{1, 0, 0});
      add_query('{-5, -5, -5}, '{-2, -8, 1}, '{mn, mx, mn});
      add_query('{mn, 0, 0}, '{mx, 0, 0}, '{mn, mn, mn});
      add_query('{mx, 0, 0}, '{mn, 0, 0}, '{1, mx, mx});
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int k = 0; k < N_RANDOM; k++) begin
         for (int i = 0; i < 3; i++) begin
            s[i] = rand_coord();
            e[i] = ($urandom_range(0, 15) == 0) ? s[i] : rand_coord();
            q[i] = rand_coord();
         end
         add_query(s, e, q);
         // Keep a short backlog, but let it grow ahead of the hold-off.
         if (k < 130 || k > 150) begin
            while (pending_queries.size() > 4) @(posedge clock);
         end
         if (k == 150) begin
            // Long receiver hold-off while the sender keeps offering.
            hold_output <= 1'b1;
            for (int c = 0; c < 3 * LATENCY; c++) @(posedge clock);
            hold_output <= 1'b0;
         end
         if (k == 380) calm_phase <= 1'b1;
      end
      while (pending_queries.size() != 0 || req_valid) @(posedge clock);
      stimulus_done <= 1'b1;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("[closest_point_on_segment_unit] OK");
      end else begin
         $display("[closest_point_on_segment_unit] ERROR");
      end
      $finish;
   end
endmodule

[sim.f]
design/cps_pkg.sv
design/cps_div_cell.sv
design/closest_point_on_segment_unit.sv
design/cps_checker.sv
tb/tb_closest_point_on_segment_unit.sv
